// ===== hdl/bsr_pkg.sv =====
`default_nettype none

package bsr_pkg;

    localparam int FRAME_COLUMNS_DEF = 24;
    localparam int FRAME_ROWS_DEF    = 7;

    localparam int MODE_W     = 3;
    localparam int POS_W      = 7;
    localparam int SIZE_W     = 6;
    localparam int COL_BITS_W = 7;
    localparam int CRD_W      = 8;
    localparam int DIST_W     = 12;

    typedef logic signed [CRD_W-1:0]  t_crd;
    typedef logic signed [DIST_W-1:0] t_dist;

    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FILL    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OUTLINE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CIRCLE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

    // midpoint circle decision constants
    localparam t_dist D_INIT      = 12'sd3;
    localparam t_dist D_INC_DIAG  = 12'sd10;
    localparam t_dist D_INC_AXIAL = 12'sd6;

    typedef struct packed {
        logic load;
        logic clear;
        logic rd;
        logic wr;
        logic capture;
        logic next;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic rect_empty;
        logic col_last;
        logic slot_last;
        logic circ_more;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hdl/bsr_ram.sv =====
`default_nettype none

module bsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bsr_datapath.sv =====
`default_nettype none

module bsr_datapath
    import bsr_pkg::*;
#(
    parameter int FRAME_COLUMNS = FRAME_COLUMNS_DEF,
    parameter int FRAME_ROWS    = FRAME_ROWS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    input  wire logic [MODE_W-1:0]     i_mode,
    input  wire logic [POS_W-1:0]      i_x_pos,
    input  wire logic [POS_W-1:0]      i_y_pos,
    input  wire logic [SIZE_W-1:0]     i_width,
    input  wire logic [SIZE_W-1:0]     i_height,
    input  wire logic [SIZE_W-1:0]     i_radius,
    output t_dp_status                 o_status,
    output logic [COL_BITS_W-1:0]      o_column_bits,
    output logic                       o_range_error
);

    localparam int   COL_AW = (FRAME_COLUMNS > 1) ? $clog2(FRAME_COLUMNS) : 1;
    localparam t_crd COLS_S = CRD_W'(FRAME_COLUMNS);
    localparam t_crd ROWS_S = CRD_W'(FRAME_ROWS);

    function automatic logic [FRAME_ROWS-1:0] f_row_bit(input t_crd row);
        logic [FRAME_ROWS-1:0] bits;
        bits = '0;
        for (int n = 0; n < FRAME_ROWS; n++) begin
            bits[n] = (row == t_crd'(n));
        end
        return bits;
    endfunction

    function automatic logic [FRAME_ROWS-1:0] f_row_span(input t_crd lo, input t_crd hi);
        logic [FRAME_ROWS-1:0] bits;
        bits = '0;
        for (int n = 0; n < FRAME_ROWS; n++) begin
            bits[n] = (t_crd'(n) >= lo) && (t_crd'(n) <= hi);
        end
        return bits;
    endfunction

    function automatic logic f_row_in(input t_crd row);
        return (row >= t_crd'(0)) && (row < ROWS_S);
    endfunction

    logic [MODE_W-1:0]     r_mode;
    t_crd                  r_x, r_y, r_xr, r_yb, r_col, r_end, r_a, r_b;
    t_dist                 r_d;
    logic                  r_h_nz, r_h_ge3, r_rect_empty, r_r_nz;
    logic [1:0]            r_slot;
    logic                  r_err;
    logic [FRAME_ROWS-1:0] r_colv;
    logic [FRAME_COLUMNS-1:0] r_vld;

    t_crd                  w_x_ext, w_y_ext, w_xr, w_yb;
    t_crd                  w_circ_col, w_circ_r0, w_circ_r1, w_col;
    logic                  w_col_in, w_err_col;
    logic [FRAME_ROWS-1:0] w_bits, w_old, w_rd_data;
    logic [COL_AW-1:0]     w_addr;
    logic                  w_in_tb, w_side;
    t_crd                  w_a_n, w_b_n, w_diff;
    t_dist                 w_d_n;
    logic [FRAME_ROWS+COL_BITS_W-1:0] w_colv_ext;

    assign w_x_ext = {i_x_pos[POS_W-1], i_x_pos};
    assign w_y_ext = {i_y_pos[POS_W-1], i_y_pos};
    assign w_xr    = w_x_ext + $signed({2'b00, i_width}) - t_crd'(1);
    assign w_yb    = w_y_ext + $signed({2'b00, i_height}) - t_crd'(1);

    // circle: four columns per step, two rows each
    always_comb begin
        case (r_slot)
            2'd0: begin
                w_circ_col = r_x + r_a;
                w_circ_r0  = r_y + r_b;
                w_circ_r1  = r_y - r_b;
            end
            2'd1: begin
                w_circ_col = r_x - r_a;
                w_circ_r0  = r_y + r_b;
                w_circ_r1  = r_y - r_b;
            end
            2'd2: begin
                w_circ_col = r_x + r_b;
                w_circ_r0  = r_y + r_a;
                w_circ_r1  = r_y - r_a;
            end
            default: begin
                w_circ_col = r_x - r_b;
                w_circ_r0  = r_y + r_a;
                w_circ_r1  = r_y - r_a;
            end
        endcase
    end

    always_comb begin
        case (r_mode)
            MODE_CIRCLE: w_col = w_circ_col;
            MODE_READ:   w_col = r_x;
            default:     w_col = r_col;
        endcase
    end

    assign w_col_in = (w_col >= t_crd'(0)) && (w_col < COLS_S);
    assign w_addr   = w_col[COL_AW-1:0];
    assign w_in_tb  = (r_col >= r_x) && (r_col <= r_xr);
    assign w_side   = (r_col == r_x) || (r_col == r_xr);

    always_comb begin
        w_bits    = '0;
        w_err_col = 1'b0;
        case (r_mode)
            MODE_FILL: begin
                w_bits    = r_h_nz ? f_row_span(r_y, r_yb) : '0;
                w_err_col = r_h_nz && (!w_col_in || !f_row_in(r_y) || !f_row_in(r_yb));
            end
            MODE_OUTLINE: begin
                if (w_in_tb) begin
                    w_bits = f_row_bit(r_y) | f_row_bit(r_yb);
                end
                if (w_side && r_h_ge3) begin
                    w_bits = w_bits | f_row_span(r_y + t_crd'(1), r_yb - t_crd'(1));
                end
                w_err_col = (w_in_tb && (!w_col_in || !f_row_in(r_y) || !f_row_in(r_yb)))
                    || (w_side && r_h_ge3 && (!w_col_in || !f_row_in(r_y + t_crd'(1))
                        || !f_row_in(r_yb - t_crd'(1))));
            end
            MODE_CIRCLE: begin
                w_bits = f_row_bit(w_circ_r0) | f_row_bit(w_circ_r1);
            end
            default: begin
                w_bits    = '0;
                w_err_col = 1'b0;
            end
        endcase
    end

    assign w_old = r_vld[w_addr] ? w_rd_data : '0;

    bsr_ram #(
        .WIDTH (FRAME_ROWS),
        .DEPTH (FRAME_COLUMNS),
        .AW    (COL_AW)
    ) u_frame (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr && w_col_in),
        .i_wr_addr (w_addr),
        .i_wr_data (w_old | w_bits),
        .i_rd_en   (i_cmd.rd && w_col_in),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_data)
    );

    // midpoint step
    assign w_a_n  = r_a + t_crd'(1);
    assign w_b_n  = (r_d > t_dist'(0)) ? r_b - t_crd'(1) : r_b;
    assign w_diff = w_a_n - w_b_n;
    assign w_d_n  = (r_d > t_dist'(0))
        ? r_d + t_dist'({{2{w_diff[CRD_W-1]}}, w_diff, 2'b00}) + D_INC_DIAG
        : r_d + t_dist'({{2{w_a_n[CRD_W-1]}}, w_a_n, 2'b00}) + D_INC_AXIAL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.clear) begin
            r_vld <= '0;
        end else if (i_cmd.wr && w_col_in) begin
            r_vld[w_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode       <= i_mode;
            r_x          <= w_x_ext;
            r_y          <= w_y_ext;
            r_xr         <= w_xr;
            r_yb         <= w_yb;
            r_h_nz       <= (i_height != '0);
            r_h_ge3      <= (i_height >= SIZE_W'(3));
            r_rect_empty <= (i_width == '0) || (i_height == '0);
            // a zero-width outline still spans x-1 and x
            r_col        <= (i_width == '0) ? w_xr : w_x_ext;
            r_end        <= (i_width == '0) ? w_x_ext : w_xr;
            r_a          <= '0;
            r_b          <= $signed({2'b00, i_radius});
            r_d          <= D_INIT - $signed({5'b0, i_radius, 1'b0});
            r_r_nz       <= (i_radius != '0);
            r_slot       <= '0;
            r_err        <= 1'b0;
            r_colv       <= '0;
        end else begin
            if (i_cmd.wr) begin
                r_err <= r_err | w_err_col;
            end
            if (i_cmd.capture) begin
                r_colv <= w_col_in ? w_old : '0;
            end
            if (i_cmd.next) begin
                r_col  <= r_col + t_crd'(1);
                r_slot <= r_slot + 2'd1;
            end
            if (i_cmd.step) begin
                r_a    <= w_a_n;
                r_b    <= w_b_n;
                r_d    <= w_d_n;
                r_slot <= '0;
            end
        end
    end

    assign w_colv_ext = {{COL_BITS_W{1'b0}}, r_colv};
    assign o_column_bits = w_colv_ext[COL_BITS_W-1:0];
    assign o_range_error = r_err;

    assign o_status.rect_empty = r_rect_empty;
    assign o_status.col_last   = (r_col == r_end);
    assign o_status.slot_last  = (r_slot == 2'd3);
    assign o_status.circ_more  = (r_a <= r_b) && r_r_nz;

endmodule

`default_nettype wire

// ===== hdl/bsr_ctrl.sv =====
`default_nettype none

module bsr_ctrl
    import bsr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic              i_out_free,
    input  wire t_dp_status        i_status,
    output t_dp_cmd                o_cmd,
    output logic                   o_stall,
    output logic                   o_done
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_WRITE  = 3'd2;
    localparam logic [2:0] S_STEP   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [MODE_W-1:0] r_mode, n_mode;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        o_cmd   = '0;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_mode     = i_mode;
                    case (i_mode)
                        MODE_CLEAR: begin
                            o_cmd.clear = 1'b1;
                            n_state     = S_FINISH;
                        end
                        MODE_FILL, MODE_OUTLINE, MODE_CIRCLE, MODE_READ: begin
                            n_state = S_READ;
                        end
                        default: n_state = S_FINISH;
                    endcase
                end
            end
            S_READ: begin
                if (r_mode == MODE_FILL && i_status.rect_empty) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_WRITE;
                end
            end
            S_WRITE: begin
                if (r_mode == MODE_READ) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_FINISH;
                end else begin
                    o_cmd.wr = 1'b1;
                    if (r_mode == MODE_CIRCLE) begin
                        if (!i_status.slot_last) begin
                            o_cmd.next = 1'b1;
                            n_state    = S_READ;
                        end else if (i_status.circ_more) begin
                            n_state = S_STEP;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end else if (i_status.col_last) begin
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.next = 1'b1;
                        n_state    = S_READ;
                    end
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = S_READ;
            end
            S_FINISH: begin
                // hold until the output register can take the result
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_CLEAR;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bitmap_shape_rasterizer.sv =====
// Monochrome frame rasterizer: FRAME_COLUMNS columns of FRAME_ROWS bits each.
// Input channel (i_valid / o_stall) takes one drawing command per transaction:
// clear, filled rectangle, rectangle outline, circle outline or column read.
// Output channel (o_valid / i_stall) returns exactly one result per command:
// the column bits for a read and the range error flag for rectangles.
// One command is worked at a time; each column touched is a read-modify-write
// of the frame memory, a read state then a write state per column.
// Controller steps after a command is accepted, each run ending in a finish
// state that waits for the output register to be free:
//   clear or unused mode: finish; column read: read, capture, finish;
//   empty filled rectangle: read state, finish; rectangle: read and write per column;
//   circle: read and write per column, four per midpoint step, then a step state.
// The next command is accepted on the cycle after the previous result is loaded.
// Reset clears the frame (per-column valid bits) and drops any pending result.
// A finished result waits in the output register while the receiver stalls;
// the next command is still accepted, and a second finished result waits in
// the controller until the output register frees up.
`default_nettype none

module bitmap_shape_rasterizer
    import bsr_pkg::*;
#(
    parameter int FRAME_COLUMNS = FRAME_COLUMNS_DEF,
    parameter int FRAME_ROWS    = FRAME_ROWS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [MODE_W-1:0]     i_mode,
    input  wire logic [POS_W-1:0]      i_x_pos,
    input  wire logic [POS_W-1:0]      i_y_pos,
    input  wire logic [SIZE_W-1:0]     i_width,
    input  wire logic [SIZE_W-1:0]     i_height,
    input  wire logic [SIZE_W-1:0]     i_radius,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [COL_BITS_W-1:0]      o_column_bits,
    output logic                       o_range_error
);

    t_dp_cmd                 w_cmd;
    t_dp_status              w_status;
    logic                    w_done, w_out_free;
    logic [COL_BITS_W-1:0]   w_column_bits;
    logic                    w_range_error;
    logic                    r_out_valid;
    logic [COL_BITS_W-1:0]   r_column_bits;
    logic                    r_range_error;

    assign w_out_free = !r_out_valid || !i_stall;

    bsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_mode     (i_mode),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_stall    (o_stall),
        .o_done     (w_done)
    );

    bsr_datapath #(
        .FRAME_COLUMNS (FRAME_COLUMNS),
        .FRAME_ROWS    (FRAME_ROWS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_mode        (i_mode),
        .i_x_pos       (i_x_pos),
        .i_y_pos       (i_y_pos),
        .i_width       (i_width),
        .i_height      (i_height),
        .i_radius      (i_radius),
        .o_status      (w_status),
        .o_column_bits (w_column_bits),
        .o_range_error (w_range_error)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_column_bits <= w_column_bits;
            r_range_error <= w_range_error;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_column_bits = r_column_bits;
    assign o_range_error = r_range_error;

    // a result never overwrites one the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (!r_out_valid || !i_stall))
        else $error("result loaded over a stalled result");

    // an accepted command blocks the input channel on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input channel open right after a command was accepted");

    // column data and range error come from disjoint modes
    a_disjoint_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_range_error || (o_column_bits == '0)))
        else $error("range error together with column data");

    // the controller finishes only while it holds a command
    a_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> o_stall)
        else $error("result produced without a command in progress");

endmodule

`default_nettype wire

// ===== tb/bitmap_shape_rasterizer_tb.sv =====
`default_nettype none

module bitmap_shape_rasterizer_tb;
    import bsr_pkg::*;

    localparam int COLS        = FRAME_COLUMNS_DEF;
    localparam int ROWS        = FRAME_ROWS_DEF;
    localparam int CYCLE_LIMIT = 3_000_000;
    // slowest command is a radius-63 circle
    localparam int DRAIN_CYCLES = 600;

    typedef struct packed {
        logic [COL_BITS_W-1:0] column_bits;
        logic                  range_error;
    } t_column_result;

    class frame_scoreboard;
        logic [ROWS-1:0] frame_cols [COLS];
        t_column_result  expected_results [$];
        int unsigned     mismatch_count;

        function new();
            foreach (frame_cols[c]) frame_cols[c] = '0;
            mismatch_count = 0;
        endfunction

        // Return 0 when the pixel falls outside the frame.
        function bit set_pixel(int col, int row);
            if (col < 0 || col >= COLS || row < 0 || row >= ROWS) return 1'b0;
            frame_cols[col][row] = 1'b1;
            return 1'b1;
        endfunction

        function bit fill_rect(int x, int y, int w, int h);
            bit off_frame = 1'b0;
            for (int c = x; c < x + w; c++)
                for (int r = y; r < y + h; r++)
                    if (!set_pixel(c, r)) off_frame = 1'b1;
            return off_frame;
        endfunction

        // Zero sizes fall out of the loop bounds: sides still get drawn.
        function bit outline_rect(int x, int y, int w, int h);
            bit off_frame = 1'b0;
            if (w == 1 && h == 1) return !set_pixel(x, y);
            for (int c = x; c < x + w; c++) begin
                if (!set_pixel(c, y)) off_frame = 1'b1;
                if (!set_pixel(c, y + h - 1)) off_frame = 1'b1;
            end
            for (int r = y + 1; r < y + h - 1; r++) begin
                if (!set_pixel(x, r)) off_frame = 1'b1;
                if (!set_pixel(x + w - 1, r)) off_frame = 1'b1;
            end
            return off_frame;
        endfunction

        function void plot_octants(int cx, int cy, int a, int b);
            void'(set_pixel(cx + a, cy + b));
            void'(set_pixel(cx + a, cy - b));
            void'(set_pixel(cx - a, cy + b));
            void'(set_pixel(cx - a, cy - b));
            void'(set_pixel(cx + b, cy + a));
            void'(set_pixel(cx + b, cy - a));
            void'(set_pixel(cx - b, cy + a));
            void'(set_pixel(cx - b, cy - a));
        endfunction

        function void draw_circle(int cx, int cy, int radius);
            int px;
            int py;
            int d;
            if (radius == 0) begin
                void'(set_pixel(cx, cy));
                return;
            end
            px = 0;
            py = radius;
            d  = int'(D_INIT) - 2 * radius;
            plot_octants(cx, cy, px, py);
            while (px <= py) begin
                px++;
                if (d > 0) begin
                    py--;
                    d += 4 * (px - py) + int'(D_INC_DIAG);
                end else begin
                    d += 4 * px + int'(D_INC_AXIAL);
                end
                plot_octants(cx, cy, px, py);
            end
        endfunction

        function void note_command(logic [MODE_W-1:0] mode, logic [POS_W-1:0] x_raw,
                                   logic [POS_W-1:0] y_raw, logic [SIZE_W-1:0] w_raw,
                                   logic [SIZE_W-1:0] h_raw, logic [SIZE_W-1:0] r_raw);
            int x;
            int y;
            t_column_result res;
            x   = int'($signed(x_raw));
            y   = int'($signed(y_raw));
            res = '0;
            case (mode)
                MODE_CLEAR:   foreach (frame_cols[c]) frame_cols[c] = '0;
                MODE_FILL:    res.range_error = fill_rect(x, y, int'(w_raw), int'(h_raw));
                MODE_OUTLINE: res.range_error = outline_rect(x, y, int'(w_raw), int'(h_raw));
                MODE_CIRCLE:  draw_circle(x, y, int'(r_raw));
                MODE_READ: begin
                    if (x >= 0 && x < COLS) res.column_bits = COL_BITS_W'(frame_cols[x]);
                end
                default: ;
            endcase
            expected_results.push_back(res);
        endfunction

        function void check_result(logic [COL_BITS_W-1:0] column_bits, logic range_error);
            t_column_result exp_res;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, %s %0h range_error %0b",
                         $time, "actual column_bits", column_bits, range_error);
                mismatch_count++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (column_bits !== exp_res.column_bits) begin
                $display("%0t: column_bits mismatch, expected %0h, actual %0h",
                         $time, exp_res.column_bits, column_bits);
                mismatch_count++;
            end
            if (range_error !== exp_res.range_error) begin
                $display("%0t: range_error mismatch, expected %0b, actual %0b",
                         $time, exp_res.range_error, range_error);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [MODE_W-1:0]     i_mode;
    logic [POS_W-1:0]      i_x_pos;
    logic [POS_W-1:0]      i_y_pos;
    logic [SIZE_W-1:0]     i_width;
    logic [SIZE_W-1:0]     i_height;
    logic [SIZE_W-1:0]     i_radius;
    logic                  o_valid;
    logic                  i_stall;
    logic [COL_BITS_W-1:0] o_column_bits;
    logic                  o_range_error;

    frame_scoreboard frame_sb;
    int              send_idle_pct;
    int              recv_stall_pct;
    int unsigned     cycle_count;

    bitmap_shape_rasterizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_x_pos       (i_x_pos),
        .i_y_pos       (i_y_pos),
        .i_width       (i_width),
        .i_height      (i_height),
        .i_radius      (i_radius),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_column_bits (o_column_bits),
        .o_range_error (o_range_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: check on accept, then pick the stall for the next cycle.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                frame_sb.check_result(o_column_bits, o_range_error);
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_command(int mode, int x, int y, int w, int h, int r);
        logic [MODE_W-1:0] mode_v;
        logic [POS_W-1:0]  x_v;
        logic [POS_W-1:0]  y_v;
        logic [SIZE_W-1:0] w_v;
        logic [SIZE_W-1:0] h_v;
        logic [SIZE_W-1:0] r_v;
        mode_v = MODE_W'(mode);
        x_v    = POS_W'(x);
        y_v    = POS_W'(y);
        w_v    = SIZE_W'(w);
        h_v    = SIZE_W'(h);
        r_v    = SIZE_W'(r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_mode   <= mode_v;
        i_x_pos  <= x_v;
        i_y_pos  <= y_v;
        i_width  <= w_v;
        i_height <= h_v;
        i_radius <= r_v;
        // hold until the transaction is taken
        do @(posedge i_clk); while (o_stall);
        frame_sb.note_command(mode_v, x_v, y_v, w_v, h_v, r_v);
    endtask

    // Mostly near the frame, now and then anywhere in the signed range.
    function automatic int pick_col();
        if ($urandom_range(99) < 80) return int'($urandom_range(31)) - 4;
        return int'($urandom_range(127)) - 64;
    endfunction

    function automatic int pick_row();
        if ($urandom_range(99) < 80) return int'($urandom_range(12)) - 3;
        return int'($urandom_range(127)) - 64;
    endfunction

    function automatic int pick_size(int typical_max);
        if ($urandom_range(99) < 85) return int'($urandom_range(typical_max));
        return int'($urandom_range(63));
    endfunction

    task automatic run_random_phase(int idle_pct, int stall_pct, int item_goal);
        int sent;
        int pick;
        int draw_mode;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < item_goal) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                send_command(MODE_CLEAR, pick_col(), pick_row(), pick_size(63),
                             pick_size(63), pick_size(63));
                sent++;
            end else if (pick < 35) begin
                case ($urandom_range(2))
                    0:       draw_mode = MODE_FILL;
                    1:       draw_mode = MODE_OUTLINE;
                    default: draw_mode = MODE_CIRCLE;
                endcase
                send_command(draw_mode, pick_col(), pick_row(), pick_size(26),
                             pick_size(9), pick_size(12));
                sent++;
            end else if (pick < 38) begin
                // unused modes: the block draws nothing for them, so they do not count
                send_command($urandom_range(7, 5), int'($urandom_range(127)),
                             int'($urandom_range(127)), pick_size(63), pick_size(63),
                             pick_size(63));
            end else if (pick < 41) begin
                // scan the whole frame plus one column past each edge
                for (int c = -1; c <= COLS; c++)
                    send_command(MODE_READ, c, pick_row(), pick_size(63), pick_size(63),
                                 pick_size(63));
                sent += COLS + 2;
            end else begin
                send_command(MODE_READ,
                             ($urandom_range(99) < 85) ? int'($urandom_range(COLS - 1))
                                                       : pick_col(),
                             pick_row(), pick_size(63), pick_size(63), pick_size(63));
                sent++;
            end
        end
    endtask

    initial begin
        frame_sb = new();
        send_idle_pct  = 10;
        recv_stall_pct = 56;
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_mode   <= '0;
        i_x_pos  <= '0;
        i_y_pos  <= '0;
        i_width  <= '0;
        i_height <= '0;
        i_radius <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // frame is clear after reset; then fill it entirely
        send_command(MODE_READ, 0, 0, 0, 0, 0);
        send_command(MODE_FILL, 0, 0, COLS, ROWS, 63);
        send_command(MODE_READ, COLS - 1, 0, 0, 0, 0);
        send_command(MODE_READ, -1, 0, 0, 0, 0);
        send_command(MODE_READ, COLS, 0, 0, 0, 0);
        send_command(MODE_READ, -64, -64, 63, 63, 63);
        send_command(MODE_READ, 63, 63, 0, 0, 0);
        send_command(MODE_CLEAR, 0, 0, 0, 0, 0);
        send_command(MODE_READ, 0, 0, 0, 0, 0);
        // rectangle hanging over the top left corner
        send_command(MODE_FILL, -2, -1, 4, 3, 0);
        send_command(MODE_FILL, 5, 2, 0, 5, 0);
        send_command(MODE_FILL, 6, 2, 5, 0, 0);
        send_command(MODE_READ, 0, 0, 0, 0, 0);
        send_command(MODE_OUTLINE, 3, 3, 1, 1, 0);
        send_command(MODE_OUTLINE, 10, 1, 0, 4, 0);
        send_command(MODE_OUTLINE, 14, 2, 3, 0, 0);
        send_command(MODE_OUTLINE, 20, 5, 63, 63, 0);
        send_command(MODE_READ, 9, 0, 0, 0, 0);
        send_command(MODE_READ, 10, 0, 0, 0, 0);
        send_command(MODE_CIRCLE, 5, 3, 0, 0, 0);
        send_command(MODE_CIRCLE, -1, -1, 0, 0, 0);
        send_command(MODE_CIRCLE, 12, 3, 0, 0, 3);
        send_command(MODE_CIRCLE, 63, 63, 0, 0, 63);
        send_command(MODE_CIRCLE, -64, -64, 63, 63, 63);
        send_command(MODE_READ, 12, 0, 0, 0, 0);
        send_command(5, 63, 63, 63, 63, 63);
        send_command(7, -1, -1, 63, 63, 63);

        run_random_phase(10, 56, 630);
        run_random_phase(56, 10, 630);
        run_random_phase(0, 0, 640);
        i_valid <= 1'b0;

        while (frame_sb.expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (frame_sb.mismatch_count == 0 && frame_sb.expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/bsr_pkg.sv
hdl/bsr_ram.sv
hdl/bsr_datapath.sv
hdl/bsr_ctrl.sv
hdl/bitmap_shape_rasterizer.sv
tb/bitmap_shape_rasterizer_tb.sv
